@@ rtl/core/mbrx_pkg.sv @@
// Shared types and constants for the Modbus RTU reply receiver.
// Holds the item, result and configuration structs, status and action codes.
// No dependencies.
`default_nettype none

package mbrx_pkg;

  // Largest frame the receiver accepts by default.
  localparam int unsigned DEF_MAX_FRAME_BYTES = 256;

  // Configuration port geometry.
  localparam int unsigned CFG_DATA_W  = 20;
  localparam int unsigned CFG_INDEX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_BYTE_COUNT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REPLY_LIMIT         = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GAP_LIMIT           = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_LIMIT         = 3'd4;

  // Configuration reset values.
  localparam logic [7:0]  RST_DEVICE_ADDRESS      = 8'd1;
  localparam logic [7:0]  RST_EXPECTED_BYTE_COUNT = 8'hA8;
  localparam logic [19:0] RST_REPLY_LIMIT         = 20'd400000;
  localparam logic [15:0] RST_GAP_LIMIT           = 16'd2870;
  localparam logic [19:0] RST_FRAME_LIMIT         = 20'd300000;

  // Modbus function code for read holding registers.
  localparam logic [7:0] FUNC_READ_HOLDING = 8'd3;

  typedef enum logic [1:0] {
    ACT_ARM  = 2'd0,
    ACT_BYTE = 2'd1,
    ACT_TICK = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_TAKEN   = 3'd0,
    ST_GOOD    = 3'd1,
    ST_NOREPLY = 3'd2,
    ST_TIMEOUT = 3'd3,
    ST_CRC     = 3'd4,
    ST_HEADER  = 3'd5,
    ST_DISCARD = 3'd6
  } status_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]  device_address;
    logic [7:0]  expected_byte_count;
    logic [19:0] reply_limit;
    logic [15:0] gap_limit;
    logic [19:0] frame_limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0] byte_index;
    logic [7:0] echo_byte;
    logic [2:0] status;
    logic       frame_end;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/modbus_rtu_reply_receiver_unit.sv @@
// Modbus RTU reply receiver: CRC-16 checked read-holding-registers reply.
// The input register loads at the transfer edge, and the result register when the core takes
// the item, which waits while a finished result is not yet accepted downstream.
// Throughput: one item per cycle unless a result waits on out_ready; CRC and timers are combinational.
// The result register holds while out_ready is low, and the input register still takes one item.
// Reset (rst, synchronous): receiver idle, timers and frame state cleared, registers at defaults.
`default_nettype none

module modbus_rtu_reply_receiver_unit #(
  parameter int unsigned MAX_FRAME_BYTES = mbrx_pkg::DEF_MAX_FRAME_BYTES
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Input item channel.
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        action,
  input  wire logic [7:0]                        rx_byte,
  // Result channel.
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [7:0]                             byte_index,
  output logic [7:0]                             echo_byte,
  output logic [2:0]                             status,
  output logic                                   frame_end,
  // Configuration write port.
  input  wire logic                              cfg_we,
  input  wire logic [mbrx_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [mbrx_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // The user must write the configuration registers only while the receiver is idle
  // (the block does not enforce it), so the core reads them directly without any shadow copy.
  mbrx_pkg::cfg_t    cfg;
  mbrx_pkg::item_t   item;
  mbrx_pkg::result_t result;
  logic              held;
  logic              take;

  mbrx_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The input register decouples the upstream transfer from the core, so one
  // new item is still taken while a finished result waits downstream.
  mbrx_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .rx_byte  (rx_byte),
    .held     (held),
    .item     (item),
    .take     (take)
  );

  // The core applies one item per cycle while the result register is free or being emptied:
  // arm, byte or microsecond tick. An item may update the phase, the two timers and the
  // running CRC, and loads at most one result into the result register.
  mbrx_core #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (held),
    .item       (item),
    .take       (take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result     (result)
  );

  assign byte_index = result.byte_index;
  assign echo_byte  = result.echo_byte;
  assign status     = result.status;
  assign frame_end  = result.frame_end;

endmodule

`default_nettype wire

@@ rtl/core/mbrx_cfg.sv @@
// Configuration register file of the Modbus RTU reply receiver.
// Depends on mbrx_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module mbrx_cfg (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [mbrx_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [mbrx_pkg::CFG_DATA_W-1:0]      cfg_data,
  output mbrx_pkg::cfg_t                            cfg
);

  mbrx_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.device_address      <= mbrx_pkg::RST_DEVICE_ADDRESS;
      regs.expected_byte_count <= mbrx_pkg::RST_EXPECTED_BYTE_COUNT;
      regs.reply_limit         <= mbrx_pkg::RST_REPLY_LIMIT;
      regs.gap_limit           <= mbrx_pkg::RST_GAP_LIMIT;
      regs.frame_limit         <= mbrx_pkg::RST_FRAME_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        mbrx_pkg::REG_DEVICE_ADDRESS:      regs.device_address      <= cfg_data[7:0];
        mbrx_pkg::REG_EXPECTED_BYTE_COUNT: regs.expected_byte_count <= cfg_data[7:0];
        mbrx_pkg::REG_REPLY_LIMIT:         regs.reply_limit         <= cfg_data[19:0];
        mbrx_pkg::REG_GAP_LIMIT:           regs.gap_limit           <= cfg_data[15:0];
        mbrx_pkg::REG_FRAME_LIMIT:         regs.frame_limit         <= cfg_data[19:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

@@ rtl/core/mbrx_in_stage.sv @@
// Input register of the Modbus RTU reply receiver.
// Holds one accepted item until the core takes it. Depends on mbrx_pkg.
`default_nettype none

module mbrx_in_stage (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [1:0]      action,
  input  wire logic [7:0]      rx_byte,
  output logic                 held,
  output mbrx_pkg::item_t      item,
  input  wire logic            take
);

  // The register refills in the same cycle that the core empties it.
  assign in_ready = !held || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (take) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.action  <= action;
      item.rx_byte <= rx_byte;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/mbrx_core.sv @@
// Receive state machine, timers, CRC-16 check and result register.
// Depends on mbrx_pkg for item_t, cfg_t, result_t and the status codes.
`default_nettype none

module mbrx_core #(
  parameter int unsigned MAX_FRAME_BYTES = mbrx_pkg::DEF_MAX_FRAME_BYTES
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire mbrx_pkg::cfg_t  cfg,
  input  wire logic            item_valid,
  input  wire mbrx_pkg::item_t item,
  output logic                 take,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output mbrx_pkg::result_t    result
);

  localparam logic [9:0] MaxLen = 10'(MAX_FRAME_BYTES);

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_FIRST  = 2'd1,
    PH_FRAME  = 2'd2,
    PH_RESYNC = 2'd3
  } phase_t;

  // CRC-16/MODBUS update for one byte, reflected polynomial 0xA001.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  phase_t      phase, phase_next;
  logic [7:0]  bytes_taken, bytes_taken_next;
  logic [15:0] running_crc, running_crc_next;
  logic [15:0] gap_ticks, gap_ticks_next;
  logic [19:0] elapsed_ticks, elapsed_ticks_next;
  logic        header_good, header_good_next;
  logic        crc_first_good, crc_first_good_next;
  logic        res_valid_next;
  mbrx_pkg::result_t res_next;

  logic [19:0] elapsed_inc;
  logic [15:0] gap_inc;
  logic [7:0]  idx_cur;
  logic [15:0] crc_cur;
  logic        hdr_cur, crcf_cur, hdr_upd, do_clear;
  logic [9:0]  frame_len, pos_sum, len_raw;
  logic [7:0]  b;

  // An item moves only when the result register is free or being emptied.
  assign take = item_valid && (!out_valid || out_ready);

  always_comb begin
    b           = item.rx_byte;
    elapsed_inc = (elapsed_ticks == 20'hFFFFF) ? elapsed_ticks : elapsed_ticks + 20'd1;
    gap_inc     = (gap_ticks == 16'hFFFF) ? gap_ticks : gap_ticks + 16'd1;
    len_raw     = {2'b00, cfg.expected_byte_count} + 10'd5;
    frame_len   = (len_raw > MaxLen) ? MaxLen : len_raw;

    // A byte while waiting for the first byte starts from a clean frame.
    if (phase == PH_FIRST) begin
      idx_cur  = 8'd0;
      crc_cur  = 16'hFFFF;
      hdr_cur  = 1'b1;
      crcf_cur = 1'b1;
    end else begin
      idx_cur  = bytes_taken;
      crc_cur  = running_crc;
      hdr_cur  = header_good;
      crcf_cur = crc_first_good;
    end
    pos_sum = {2'b00, idx_cur} + 10'd2;
    hdr_upd = hdr_cur;
    if (idx_cur == 8'd0 && b != cfg.device_address)         hdr_upd = 1'b0;
    if (idx_cur == 8'd1 && b != mbrx_pkg::FUNC_READ_HOLDING) hdr_upd = 1'b0;
    if (idx_cur == 8'd2 && b != cfg.expected_byte_count)    hdr_upd = 1'b0;

    phase_next          = phase;
    bytes_taken_next    = bytes_taken;
    running_crc_next    = running_crc;
    gap_ticks_next      = gap_ticks;
    elapsed_ticks_next  = elapsed_ticks;
    header_good_next    = header_good;
    crc_first_good_next = crc_first_good;
    res_valid_next      = 1'b0;
    res_next            = '0;
    do_clear            = 1'b0;

    case (mbrx_pkg::action_t'(item.action))
      mbrx_pkg::ACT_ARM: begin
        phase_next         = PH_FIRST;
        elapsed_ticks_next = 20'd0;
        do_clear           = 1'b1;
      end
      mbrx_pkg::ACT_BYTE: begin
        if (phase != PH_IDLE) begin
          if (phase == PH_FIRST) begin
            elapsed_ticks_next = 20'd0;
          end
          phase_next          = PH_FRAME;
          gap_ticks_next      = 16'd0;
          res_valid_next      = 1'b1;
          res_next.byte_index = idx_cur;
          res_next.echo_byte  = b;
          res_next.status     = mbrx_pkg::ST_TAKEN;
          res_next.frame_end  = 1'b0;
          if (pos_sum < frame_len) begin
            running_crc_next    = crc16_byte(crc_cur, b);
            bytes_taken_next    = idx_cur + 8'd1;
            header_good_next    = hdr_upd;
            crc_first_good_next = crcf_cur;
          end else if (pos_sum == frame_len) begin
            running_crc_next    = crc_cur;
            bytes_taken_next    = idx_cur + 8'd1;
            header_good_next    = hdr_upd;
            crc_first_good_next = crcf_cur && (b == crc_cur[7:0]);
          end else begin
            // Last byte: CRC verdict first, then the header.
            if (!crcf_cur || b != crc_cur[15:8]) begin
              res_next.status = mbrx_pkg::ST_CRC;
            end else if (!hdr_upd) begin
              res_next.status = mbrx_pkg::ST_HEADER;
            end else begin
              res_next.status = mbrx_pkg::ST_GOOD;
            end
            res_next.frame_end = 1'b1;
            phase_next         = PH_IDLE;
            do_clear           = 1'b1;
          end
        end
      end
      mbrx_pkg::ACT_TICK: begin
        if (phase != PH_IDLE) begin
          elapsed_ticks_next = elapsed_inc;
          case (phase)
            PH_FIRST: begin
              if (elapsed_inc >= cfg.reply_limit) begin
                phase_next         = PH_IDLE;
                do_clear           = 1'b1;
                res_valid_next     = 1'b1;
                res_next.status    = mbrx_pkg::ST_NOREPLY;
                res_next.frame_end = 1'b1;
              end
            end
            PH_RESYNC: begin
              if (elapsed_inc > cfg.frame_limit) begin
                phase_next         = PH_IDLE;
                do_clear           = 1'b1;
                res_valid_next     = 1'b1;
                res_next.status    = mbrx_pkg::ST_TIMEOUT;
                res_next.frame_end = 1'b1;
              end
            end
            default: begin
              gap_ticks_next = gap_inc;
              if (gap_inc > cfg.gap_limit) begin
                do_clear       = 1'b1;
                res_valid_next = 1'b1;
                if (elapsed_inc > cfg.frame_limit) begin
                  phase_next         = PH_IDLE;
                  res_next.status    = mbrx_pkg::ST_TIMEOUT;
                  res_next.frame_end = 1'b1;
                end else begin
                  phase_next         = PH_RESYNC;
                  res_next.status    = mbrx_pkg::ST_DISCARD;
                  res_next.frame_end = 1'b0;
                end
              end
            end
          endcase
        end
      end
      default: begin
      end
    endcase

    if (do_clear) begin
      bytes_taken_next    = 8'd0;
      running_crc_next    = 16'hFFFF;
      gap_ticks_next      = 16'd0;
      header_good_next    = 1'b1;
      crc_first_good_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      bytes_taken    <= 8'd0;
      running_crc    <= 16'hFFFF;
      gap_ticks      <= 16'd0;
      elapsed_ticks  <= 20'd0;
      header_good    <= 1'b1;
      crc_first_good <= 1'b1;
      out_valid      <= 1'b0;
    end else if (take) begin
      phase          <= phase_next;
      bytes_taken    <= bytes_taken_next;
      running_crc    <= running_crc_next;
      gap_ticks      <= gap_ticks_next;
      elapsed_ticks  <= elapsed_ticks_next;
      header_good    <= header_good_next;
      crc_first_good <= crc_first_good_next;
      out_valid      <= res_valid_next;
      if (res_valid_next) begin
        result <= res_next;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // A result that ends the reception leaves the receiver idle.
  a_end_goes_idle: assert property (@(posedge clk) disable iff (rst)
    take && res_valid_next && res_next.frame_end |=> phase == PH_IDLE)
    else $error("reception ended but receiver is not idle");

  // Only byte-taken and partial-discarded results keep the reception open.
  a_end_matches_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((result.status == mbrx_pkg::ST_TAKEN ||
                    result.status == mbrx_pkg::ST_DISCARD) == !result.frame_end))
    else $error("frame_end disagrees with status");

  // Timer results carry no byte.
  a_timer_no_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result.status == mbrx_pkg::ST_NOREPLY ||
                  result.status == mbrx_pkg::ST_TIMEOUT ||
                  result.status == mbrx_pkg::ST_DISCARD)
      |-> result.byte_index == 8'd0 && result.echo_byte == 8'd0)
    else $error("timer result carries byte data");

  // While idle the frame state is clean.
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> bytes_taken == 8'd0 && running_crc == 16'hFFFF &&
                         header_good && crc_first_good)
    else $error("idle with frame state left over");

  // Arming restarts the reply wait.
  a_arm_restarts: assert property (@(posedge clk) disable iff (rst)
    take && item.action == mbrx_pkg::ACT_ARM |=> phase == PH_FIRST && elapsed_ticks == 20'd0)
    else $error("arm did not restart the reply wait");

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the Modbus RTU reply receiver unit.
// Needs mbrx_pkg and modbus_rtu_reply_receiver_unit; feeds arm, byte and tick items over
// valid/ready, predicts every result in the testbench and checks each transfer in a monitor.

module tb;
  import mbrx_pkg::*;

  // Action code 3 has no meaning; the receiver must ignore it.
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int FRAME_CAP = 256;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Receiver progress as the predictor tracks it.
  typedef enum logic [1:0] {RX_IDLE, RX_WAIT_FIRST, RX_IN_FRAME, RX_RESYNC} rx_phase_t;

  // Ways a generated reply frame can be damaged.
  typedef enum int {FLAW_NONE, FLAW_CRC_LO, FLAW_CRC_HI, FLAW_HEADER, FLAW_CUT} frame_flaw_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Every block input starts at a known value.
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] action = ACT_TICK;
  logic [7:0] rx_byte = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] byte_index;
  logic [7:0] echo_byte;
  logic [2:0] status;
  logic frame_end;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Pending input items and replies that are still owed by the block.
  item_t pending_items[$];
  result_t expected_replies[$];
  int items_queued = 0;
  int items_accepted = 0;
  int failures = 0;

  // Per-phase switches that turn random idling off on either side.
  logic sender_steady = 1'b0;
  logic receiver_steady = 1'b0;

  // Predictor copy of the configuration and the receiver state.
  cfg_t model_cfg;
  rx_phase_t rx_phase;
  logic [7:0] rx_count;
  logic [15:0] rx_crc;
  logic [15:0] gap_cnt;
  logic [19:0] since_first;
  logic hdr_ok;
  logic crc_lo_ok;

  modbus_rtu_reply_receiver_unit i_dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // A hard stop in case the block hangs and a handshake never completes.
  initial begin
    #15_000_000;
    $display("[modbus_rtu_reply_receiver_unit] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------------------

  // One byte of CRC-16 in the reflected form: shift right, fold in the polynomial on a one.
  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    int k;
    c = crc ^ {8'h00, data};
    for (k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  // Frame length is the payload count plus address, function, count and two CRC bytes,
  // capped at the largest frame the receiver holds.
  function automatic int reply_len();
    int n;
    n = int'(model_cfg.expected_byte_count) + 5;
    return (n > FRAME_CAP) ? FRAME_CAP : n;
  endfunction

  // Drops everything learned about the current frame but leaves the elapsed timer alone.
  function automatic void restart_frame();
    rx_count = '0;
    rx_crc = CRC_INIT;
    gap_cnt = '0;
    hdr_ok = 1'b1;
    crc_lo_ok = 1'b1;
  endfunction

  // Advances the predicted receiver by one accepted item. Returns 1 when the item causes a
  // result and fills in the reply that the block must produce for it.
  function automatic bit predict_reply(input item_t it, output result_t res);
    int len;
    int idx;
    res = '0;
    case (it.action)
      ACT_ARM: begin
        // Arming restarts reception from any phase, even mid-frame.
        rx_phase = RX_WAIT_FIRST;
        since_first = '0;
        restart_frame();
      end
      ACT_BYTE: begin
        if (rx_phase == RX_IDLE) return 1'b0;
        // The first byte of a reply starts the frame timer. A byte after a discard starts a
        // new frame at index zero but keeps the timer running.
        if (rx_phase == RX_WAIT_FIRST) begin
          since_first = '0;
          restart_frame();
        end
        rx_phase = RX_IN_FRAME;
        gap_cnt = '0;
        len = reply_len();
        idx = rx_count;
        if (idx == 0 && it.rx_byte != model_cfg.device_address) hdr_ok = 1'b0;
        if (idx == 1 && it.rx_byte != FUNC_READ_HOLDING) hdr_ok = 1'b0;
        if (idx == 2 && it.rx_byte != model_cfg.expected_byte_count) hdr_ok = 1'b0;
        res.byte_index = idx[7:0];
        res.echo_byte = it.rx_byte;
        res.status = ST_TAKEN;
        if (idx + 2 < len) begin
          rx_crc = crc16_update(rx_crc, it.rx_byte);
        end else if (idx + 2 == len) begin
          if (it.rx_byte != rx_crc[7:0]) crc_lo_ok = 1'b0;
        end else begin
          // Last byte: the CRC verdict outranks the header verdict.
          if (!crc_lo_ok || it.rx_byte != rx_crc[15:8]) res.status = ST_CRC;
          else if (!hdr_ok) res.status = ST_HEADER;
          else res.status = ST_GOOD;
          res.frame_end = 1'b1;
          rx_phase = RX_IDLE;
          restart_frame();
          return 1'b1;
        end
        rx_count = rx_count + 8'd1;
        return 1'b1;
      end
      ACT_TICK: begin
        if (rx_phase == RX_IDLE) return 1'b0;
        if (since_first != 20'hFFFFF) since_first = since_first + 20'd1;
        if (rx_phase == RX_WAIT_FIRST) begin
          if (since_first < model_cfg.reply_limit) return 1'b0;
          res.status = ST_NOREPLY;
          res.frame_end = 1'b1;
          rx_phase = RX_IDLE;
          restart_frame();
          return 1'b1;
        end
        if (rx_phase == RX_RESYNC) begin
          if (since_first <= model_cfg.frame_limit) return 1'b0;
          res.status = ST_TIMEOUT;
          res.frame_end = 1'b1;
          rx_phase = RX_IDLE;
          restart_frame();
          return 1'b1;
        end
        if (gap_cnt != 16'hFFFF) gap_cnt = gap_cnt + 16'd1;
        if (gap_cnt <= model_cfg.gap_limit) return 1'b0;
        // The gap broke the frame. Past the frame limit this ends the reception.
        restart_frame();
        if (since_first > model_cfg.frame_limit) begin
          res.status = ST_TIMEOUT;
          res.frame_end = 1'b1;
          rx_phase = RX_IDLE;
        end else begin
          res.status = ST_DISCARD;
          rx_phase = RX_RESYNC;
        end
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------------------

  task automatic push_item(input logic [1:0] a, input logic [7:0] b);
    item_t it;
    it.action = a;
    it.rx_byte = b;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic push_ticks(input int n);
    int k;
    for (k = 0; k < n; k++) push_item(ACT_TICK, 8'($urandom));
  endtask

  // Builds a reply frame for the current settings with random payload, damaged or cut as flaw
  // asks, and sends it with short random tick gaps between bytes, fewer of them in long frames.
  // Now and then a gap is long enough to break it.
  task automatic push_frame(input frame_flaw_t flaw);
    logic [7:0] fb [FRAME_CAP];
    logic [15:0] crc;
    int len;
    int cut;
    int k;
    int r;
    int gap;
    len = reply_len();
    gap = model_cfg.gap_limit;
    fb[0] = model_cfg.device_address;
    fb[1] = FUNC_READ_HOLDING;
    fb[2] = model_cfg.expected_byte_count;
    for (k = 3; k < len; k++) fb[k] = 8'($urandom);
    // A header fault is made before the CRC so that only the header check trips.
    if (flaw == FLAW_HEADER) begin
      r = $urandom_range(0, 2);
      fb[r] = fb[r] ^ 8'($urandom_range(1, 255));
    end
    crc = CRC_INIT;
    for (k = 0; k < len - 2; k++) crc = crc16_update(crc, fb[k]);
    fb[len-2] = crc[7:0];
    fb[len-1] = crc[15:8];
    if (flaw == FLAW_CRC_LO) fb[len-2] = fb[len-2] ^ 8'($urandom_range(1, 255));
    if (flaw == FLAW_CRC_HI) fb[len-1] = fb[len-1] ^ 8'($urandom_range(1, 255));
    cut = (flaw == FLAW_CUT && gap <= 64) ? $urandom_range(1, len - 1) : len;
    for (k = 0; k < cut; k++) begin
      if (k > 0) begin
        r = $urandom_range(0, 99);
        if (r < 2 && gap <= 6) push_ticks(gap + 1);
        else if (r >= ((len > 32) ? 96 : 60))
          push_ticks($urandom_range(0, (gap < 3) ? gap : 3));
      end
      push_item(ACT_BYTE, fb[k]);
    end
    // A cut frame is followed by just enough silence to have it thrown away.
    if (cut < len) push_ticks(gap + 1);
  endtask

  // One request/reply exchange: arm, wait a while, then a mostly well-formed reply or none.
  task automatic push_exchange();
    frame_flaw_t flaw;
    int lim;
    int r;
    push_item(ACT_ARM, 8'($urandom));
    if (model_cfg.reply_limit <= 8 && $urandom_range(0, 7) == 0) begin
      push_ticks((model_cfg.reply_limit == 0) ? 1 : int'(model_cfg.reply_limit));
      return;
    end
    if (model_cfg.reply_limit == 0) lim = 0;
    else lim = (model_cfg.reply_limit > 6) ? 5 : int'(model_cfg.reply_limit) - 1;
    push_ticks($urandom_range(0, lim));
    r = $urandom_range(0, 99);
    flaw = (r < 55) ? FLAW_NONE : (r < 65) ? FLAW_CRC_LO : (r < 75) ? FLAW_CRC_HI :
           (r < 85) ? FLAW_HEADER : FLAW_CUT;
    push_frame(flaw);
    if (flaw == FLAW_CUT) begin
      r = $urandom_range(0, 9);
      // Either resync onto a fresh frame, run the frame timer out, or just leave it hanging.
      if (r < 4) push_frame(FLAW_NONE);
      else if (r < 7)
        push_ticks((model_cfg.frame_limit < 78) ? int'(model_cfg.frame_limit) + 2 : 80);
    end
  endtask

  // Short bursts of arbitrary items, including the unused action code.
  task automatic push_noise();
    int k;
    for (k = $urandom_range(1, 6); k > 0; k--)
      push_item(2'($urandom_range(0, 3)), 8'($urandom));
  endtask

  task automatic run_traffic(input int n);
    int base;
    base = items_queued;
    while (items_queued - base < n) begin
      if ($urandom_range(0, 9) < 8) push_exchange();
      else push_noise();
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_DEVICE_ADDRESS:      model_cfg.device_address = val[7:0];
      REG_EXPECTED_BYTE_COUNT: model_cfg.expected_byte_count = val[7:0];
      REG_REPLY_LIMIT:         model_cfg.reply_limit = val[19:0];
      REG_GAP_LIMIT:           model_cfg.gap_limit = val[15:0];
      REG_FRAME_LIMIT:         model_cfg.frame_limit = val[19:0];
      default: ;
    endcase
  endtask

  // Writes all five registers and picks the idling style of the coming phase.
  task automatic load_config(input logic [7:0] dev, input logic [7:0] count,
                             input logic [19:0] reply, input logic [15:0] gap,
                             input logic [19:0] frame);
    write_reg(REG_DEVICE_ADDRESS, CFG_DATA_W'(dev));
    write_reg(REG_EXPECTED_BYTE_COUNT, CFG_DATA_W'(count));
    write_reg(REG_REPLY_LIMIT, CFG_DATA_W'(reply));
    write_reg(REG_GAP_LIMIT, CFG_DATA_W'(gap));
    write_reg(REG_FRAME_LIMIT, CFG_DATA_W'(frame));
    @(posedge clk);
    cfg_we <= 1'b0;
    sender_steady <= ($urandom_range(0, 3) == 0);
    receiver_steady <= ($urandom_range(0, 3) == 0);
  endtask

  // The sender stops here until every item is taken and every owed reply has arrived. Ticks
  // and ignored items leave no reply, so the task then also lets the two-stage pipeline empty.
  task automatic wait_drained();
    do @(posedge clk); while (items_accepted != items_queued || expected_replies.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------------------
  // Driver: presents queued items, holds each one until its transfer, then sometimes idles a while.
  // The prediction is made at the very edge where the transfer happens.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin : sender
    item_t cur;
    result_t reply;
    logic next_valid;
    int send_gap;
    int r;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      next_valid = in_valid;
      if (in_valid && in_ready) begin
        cur.action = action;
        cur.rx_byte = rx_byte;
        if (predict_reply(cur, reply)) expected_replies.push_back(reply);
        items_accepted++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_items.size() != 0) begin
          cur = pending_items.pop_front();
          action <= cur.action;
          rx_byte <= cur.rx_byte;
          next_valid = 1'b1;
          // Mostly back to back or short gaps, once in a while a long pause.
          r = $urandom_range(0, 99);
          if (sender_steady || r < 55) send_gap = 0;
          else if (r < 90) send_gap = $urandom_range(1, 3);
          else send_gap = $urandom_range(8, 40);
        end
      end
      in_valid <= next_valid;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Monitor: checks each result transfer against the oldest owed reply and drives out_ready.
  // At a few points it refuses results for a long stretch, so the block backs up and has
  // to stall its input while the driver keeps offering items.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin : receiver
    result_t want;
    int results_seen;
    int hold_left;
    int stall_left;
    int r;
    if (rst) begin
      out_ready <= 1'b0;
      results_seen = 0;
      hold_left = 0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_replies.size() == 0) begin
          $error("result with nothing owed: byte_index %0d echo_byte 0x%02h status %0d end %0b",
                 byte_index, echo_byte, status, frame_end);
          failures++;
        end else begin
          want = expected_replies.pop_front();
          if (byte_index !== want.byte_index) begin
            $error("byte_index: expected %0d, got %0d", want.byte_index, byte_index);
            failures++;
          end
          if (echo_byte !== want.echo_byte) begin
            $error("echo_byte: expected 0x%02h, got 0x%02h", want.echo_byte, echo_byte);
            failures++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            failures++;
          end
          if (frame_end !== want.frame_end) begin
            $error("frame_end: expected %0b, got %0b", want.frame_end, frame_end);
            failures++;
          end
        end
        if (results_seen % 200 == 60) hold_left = 250;
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (!receiver_steady) begin
        r = $urandom_range(0, 99);
        if (r >= 95) stall_left = $urandom_range(10, 40);
        else if (r >= 70) stall_left = $urandom_range(1, 3);
      end
      out_ready <= (hold_left == 0 && stall_left == 0);
    end
  end

  // ---------------------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------------------
  initial begin : stimulus
    int ph;
    // The predictor starts where the block does after reset.
    model_cfg.device_address = RST_DEVICE_ADDRESS;
    model_cfg.expected_byte_count = RST_EXPECTED_BYTE_COUNT;
    model_cfg.reply_limit = RST_REPLY_LIMIT;
    model_cfg.gap_limit = RST_GAP_LIMIT;
    model_cfg.frame_limit = RST_FRAME_LIMIT;
    rx_phase = RX_IDLE;
    since_first = '0;
    restart_frame();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // With the reset settings and no arm, a byte, a tick and the unused code do nothing.
    push_item(ACT_BYTE, 8'hFF);
    push_item(ACT_TICK, 8'h00);
    push_item(ACT_UNUSED, 8'hA5);
    wait_drained();

    // Directed part with five-byte frames and tight timers.
    load_config(8'h5A, 8'd0, 20'd2, 16'd1, 20'd6);
    push_item(ACT_ARM, 8'h00);
    push_ticks(2);                    // no reply: the second tick reaches the limit
    push_item(ACT_ARM, 8'h00);
    push_item(ACT_ARM, 8'hFF);        // arming again while waiting just restarts
    push_frame(FLAW_NONE);
    push_item(ACT_ARM, 8'h00);
    push_frame(FLAW_CRC_HI);
    push_item(ACT_ARM, 8'h00);
    push_frame(FLAW_HEADER);
    push_item(ACT_ARM, 8'h00);
    push_item(ACT_BYTE, 8'h5A);
    push_ticks(2);                    // gap over the limit: partial frame discarded
    push_item(ACT_BYTE, 8'h00);       // resync: new frame at index zero, timer keeps going
    push_ticks(2);                    // discarded again, still inside the frame limit
    push_ticks(3);                    // waiting for a new frame runs past the frame limit
    wait_drained();

    // Random phases with small frames and short timers.
    for (ph = 0; ph < 3; ph++) begin
      load_config(8'($urandom), 8'($urandom_range(0, 6)), 20'($urandom_range(1, 6)),
                  16'($urandom_range(0, 4)), 20'($urandom_range(4, 60)));
      run_traffic(40);
      wait_drained();
    end

    // All registers at their lowest: any tick ends the wait, any gap ends the frame.
    load_config(8'h00, 8'h00, 20'd0, 16'd0, 20'd0);
    run_traffic(30);
    wait_drained();

    // All limits at their highest and a byte count past the largest frame: the length
    // saturates at 256 bytes and no timer can fire.
    load_config(8'hFF, 8'd255, 20'hFFFFF, 16'hFFFF, 20'hFFFFF);
    push_item(ACT_ARM, 8'h00);
    push_ticks(3);
    push_frame(FLAW_NONE);
    wait_drained();

    // One more random phase back at small sizes.
    load_config(8'($urandom), 8'($urandom_range(0, 4)), 20'($urandom_range(1, 8)),
                16'($urandom_range(1, 3)), 20'($urandom_range(8, 40)));
    run_traffic(40);
    wait_drained();

    if (expected_replies.size() != 0) begin
      $error("%0d owed replies never arrived", expected_replies.size());
      failures++;
    end
    if (failures == 0) begin
      $display("[modbus_rtu_reply_receiver_unit] OK");
    end else begin
      $display("[modbus_rtu_reply_receiver_unit] ERROR");
    end
    $finish;
  end

endmodule
